>>> src/brex_pkg.sv
package brex_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DIM_W       = 11;
	localparam int FIELD_W     = 10;
	// wide enough for a clamped dimension and for the register value itself
	localparam int WLEN_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int HLEN_W      = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int OUT_DEPTH   = 4;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = OPTR_W + 1;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last_col;
		logic             last_row;
		logic             pixel;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] run_row;
		logic [FIELD_W-1:0] run_begin;
		logic [FIELD_W-1:0] run_end;
		logic [FIELD_W-1:0] count_above;
		logic [FIELD_W-1:0] count_below;
		logic               last;
	} rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic [OCNT_W-1:0] out_count;
	} back_status_t;

	function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] c);
		return (c == {FIELD_W{1'b1}}) ? c : c + FIELD_W'(1);
	endfunction

endpackage

>>> src/brex_front.sv
module brex_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pixel_valid,
	input  logic                              pixel,
	output logic                              pixel_stall,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [0:0]                        cfg_index,
	input  logic [brex_pkg::DIM_W-1:0]        cfg_data,
	input  brex_pkg::queue_status_t           q_status,
	output logic                              push,
	output brex_pkg::item_t                   item
);

	localparam int COL_W  = brex_pkg::COL_W;
	localparam int ROW_W  = brex_pkg::ROW_W;
	localparam int DIM_W  = brex_pkg::DIM_W;
	localparam int WLEN_W = brex_pkg::WLEN_W;
	localparam int HLEN_W = brex_pkg::HLEN_W;

	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WLEN_W-1:0] width_ext;
	logic [WLEN_W-1:0] width_eff;
	logic [HLEN_W-1:0] height_ext;
	logic [HLEN_W-1:0] height_eff;
	logic              last_col;
	logic              last_row;

	assign cfg_ready   = 1'b1;
	assign pixel_stall = q_status.full;
	assign push        = pixel_valid && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= brex_pkg::WIDTH_RESET;
			image_height_q <= brex_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (brex_pkg::cfg_reg_t'(cfg_index))
				brex_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				brex_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
			endcase
		end
	end

	// zero acts as one, anything past the maximum as the maximum
	always_comb begin
		width_ext  = WLEN_W'(image_width_q);
		height_ext = HLEN_W'(image_height_q);
		if (width_ext == '0) begin
			width_eff = WLEN_W'(1);
		end else if (width_ext > WLEN_W'(brex_pkg::MAX_WIDTH)) begin
			width_eff = WLEN_W'(brex_pkg::MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		if (height_ext == '0) begin
			height_eff = HLEN_W'(1);
		end else if (height_ext > HLEN_W'(brex_pkg::MAX_HEIGHT)) begin
			height_eff = HLEN_W'(brex_pkg::MAX_HEIGHT);
		end else begin
			height_eff = height_ext;
		end
	end

	assign last_col = WLEN_W'(col_q) >= width_eff - WLEN_W'(1);
	assign last_row = HLEN_W'(row_q) >= height_eff - HLEN_W'(1);

	always_comb begin
		item.col      = col_q;
		item.row      = row_q;
		item.last_col = last_col;
		item.last_row = last_row;
		item.pixel    = pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

>>> src/brex_queue.sv
module brex_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  brex_pkg::item_t         item_in,
	input  logic                    pop,
	output brex_pkg::item_t         item_out,
	output brex_pkg::queue_status_t status
);

	localparam int DEPTH  = brex_pkg::QUEUE_DEPTH;
	localparam int QPTR_W = brex_pkg::QPTR_W;
	localparam int QCNT_W = brex_pkg::QCNT_W;

	brex_pkg::item_t   entries_q [DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign item_out     = entries_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

>>> src/brex_back.sv
module brex_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brex_pkg::item_t               item,
	input  brex_pkg::queue_status_t       q_status,
	output logic                          pop,
	output logic                          run_valid,
	input  logic                          run_stall,
	output logic [brex_pkg::FIELD_W-1:0]  run_row,
	output logic [brex_pkg::FIELD_W-1:0]  run_begin,
	output logic [brex_pkg::FIELD_W-1:0]  run_end,
	output logic [brex_pkg::FIELD_W-1:0]  count_above,
	output logic [brex_pkg::FIELD_W-1:0]  count_below,
	output logic                          last,
	output brex_pkg::back_status_t        status
);

	localparam int MAX_WIDTH = brex_pkg::MAX_WIDTH;
	localparam int COL_W     = brex_pkg::COL_W;
	localparam int ROW_W     = brex_pkg::ROW_W;
	localparam int FIELD_W   = brex_pkg::FIELD_W;
	localparam int OUT_DEPTH = brex_pkg::OUT_DEPTH;
	localparam int OPTR_W    = brex_pkg::OPTR_W;
	localparam int OCNT_W    = brex_pkg::OCNT_W;

	// line stores, one per row parity
	logic mem_bank0_q [MAX_WIDTH];
	logic mem_bank1_q [MAX_WIDTH];

	brex_pkg::item_t    item_s1;
	logic               valid_s1;
	logic               rd0_s1;
	logic               rd1_s1;
	logic               fire;
	logic               wr_bank;

	logic               mid_in_run_q;
	logic [FIELD_W-1:0] mid_begin_q;
	logic [FIELD_W-1:0] mid_above_q;
	logic [FIELD_W-1:0] mid_below_q;
	logic [1:0]         nb_prev_q;
	logic               tail_in_run_q;
	logic [FIELD_W-1:0] tail_begin_q;
	logic [FIELD_W-1:0] tail_above_q;

	logic               mid_in_run_d;
	logic [FIELD_W-1:0] mid_begin_d;
	logic [FIELD_W-1:0] mid_above_d;
	logic [FIELD_W-1:0] mid_below_d;
	logic               tail_in_run_d;
	logic [FIELD_W-1:0] tail_begin_d;
	logic [FIELD_W-1:0] tail_above_d;

	logic               m_bit;
	logic               a_bit;
	logic [FIELD_W-1:0] col_f;
	logic [FIELD_W-1:0] col_m1_f;
	logic [FIELD_W-1:0] row_f;
	logic [FIELD_W-1:0] row_m1_f;
	logic               emit_mid;
	logic               emit_tail;
	brex_pkg::rec_t     rec_mid;
	brex_pkg::rec_t     rec_tail;

	brex_pkg::rec_t     out_q [OUT_DEPTH];
	logic [OPTR_W-1:0]  out_wr_q;
	logic [OPTR_W-1:0]  out_rd_q;
	logic [OCNT_W-1:0]  out_count_q;
	logic               out_take;
	logic [OCNT_W-1:0]  out_push_n;

	// room for the two records one pixel may cause
	assign fire    = valid_s1 && (out_count_q <= OCNT_W'(OUT_DEPTH - 2));
	assign pop     = !q_status.empty && (!valid_s1 || fire);
	assign wr_bank = item_s1.row[0];

	// read data bypasses the write of the pixel retiring in the same cycle
	always_ff @(posedge clk) begin
		if (fire && !wr_bank) begin
			mem_bank0_q[item_s1.col] <= item_s1.pixel;
		end
		if (fire && wr_bank) begin
			mem_bank1_q[item_s1.col] <= item_s1.pixel;
		end
		if (pop) begin
			item_s1 <= item;
			rd0_s1  <= (fire && !wr_bank && item_s1.col == item.col) ?
				item_s1.pixel : mem_bank0_q[item.col];
			rd1_s1  <= (fire && wr_bank && item_s1.col == item.col) ?
				item_s1.pixel : mem_bank1_q[item.col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// row above sits in the bank of the other parity, row two above in our own
	assign m_bit = (item_s1.row != '0) && (item_s1.row[0] ? rd0_s1 : rd1_s1);
	assign a_bit = (item_s1.row > ROW_W'(1)) && (item_s1.row[0] ? rd1_s1 : rd0_s1);

	assign col_f    = FIELD_W'(item_s1.col);
	assign col_m1_f = FIELD_W'(item_s1.col - COL_W'(1));
	assign row_f    = FIELD_W'(item_s1.row);
	assign row_m1_f = FIELD_W'(item_s1.row - ROW_W'(1));

	always_comb begin
		mid_in_run_d  = mid_in_run_q;
		mid_begin_d   = mid_begin_q;
		mid_above_d   = mid_above_q;
		mid_below_d   = mid_below_q;
		tail_in_run_d = tail_in_run_q;
		tail_begin_d  = tail_begin_q;
		tail_above_d  = tail_above_q;
		emit_mid      = 1'b0;
		emit_tail     = 1'b0;
		rec_mid       = '0;
		rec_tail      = '0;

		// run of the row above, rebuilt from the line store
		if (m_bit) begin
			if (!mid_in_run_q) begin
				mid_in_run_d = 1'b1;
				mid_begin_d  = col_f;
				mid_above_d  = FIELD_W'(a_bit);
				mid_below_d  = FIELD_W'(item_s1.pixel);
			end else begin
				if (a_bit && !nb_prev_q[0]) begin
					mid_above_d = brex_pkg::sat_inc(mid_above_q);
				end
				if (item_s1.pixel && !nb_prev_q[1]) begin
					mid_below_d = brex_pkg::sat_inc(mid_below_q);
				end
			end
			if (item_s1.last_col) begin
				emit_mid     = 1'b1;
				mid_in_run_d = 1'b0;
				rec_mid.run_end = col_f;
			end
		end else if (mid_in_run_q) begin
			emit_mid        = 1'b1;
			mid_in_run_d    = 1'b0;
			rec_mid.run_end = col_m1_f;
		end
		rec_mid.run_row     = row_m1_f;
		rec_mid.run_begin   = mid_begin_d;
		rec_mid.count_above = mid_above_d;
		rec_mid.count_below = mid_below_d;

		// run of the current row, only reported on the last row
		if (item_s1.pixel) begin
			if (!tail_in_run_q) begin
				tail_in_run_d = 1'b1;
				tail_begin_d  = col_f;
				tail_above_d  = FIELD_W'(m_bit);
			end else if (m_bit && !mid_in_run_q) begin
				tail_above_d = brex_pkg::sat_inc(tail_above_q);
			end
			if (item_s1.last_col) begin
				emit_tail        = item_s1.last_row;
				tail_in_run_d    = 1'b0;
				rec_tail.run_end = col_f;
			end
		end else if (tail_in_run_q) begin
			emit_tail        = item_s1.last_row;
			tail_in_run_d    = 1'b0;
			rec_tail.run_end = col_m1_f;
		end
		rec_tail.run_row     = row_f;
		rec_tail.run_begin   = tail_begin_d;
		rec_tail.count_above = tail_above_d;
		rec_tail.count_below = '0;

		rec_mid.last  = !emit_tail;
		rec_tail.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_in_run_q  <= 1'b0;
			mid_begin_q   <= '0;
			mid_above_q   <= '0;
			mid_below_q   <= '0;
			nb_prev_q     <= '0;
			tail_in_run_q <= 1'b0;
			tail_begin_q  <= '0;
			tail_above_q  <= '0;
		end else if (fire) begin
			mid_in_run_q  <= mid_in_run_d;
			mid_begin_q   <= mid_begin_d;
			mid_above_q   <= mid_above_d;
			mid_below_q   <= mid_below_d;
			nb_prev_q     <= item_s1.last_col ? 2'b00 : {item_s1.pixel, a_bit};
			tail_in_run_q <= tail_in_run_d;
			tail_begin_q  <= tail_begin_d;
			tail_above_q  <= tail_above_d;
		end
	end

	// result queue, up to two records written per transaction
	assign out_take   = run_valid && !run_stall;
	assign out_push_n = fire ? (OCNT_W'(emit_mid) + OCNT_W'(emit_tail)) : '0;

	always_ff @(posedge clk) begin
		if (fire && emit_mid) begin
			out_q[out_wr_q] <= rec_mid;
		end
		if (fire && emit_tail) begin
			out_q[out_wr_q + OPTR_W'(emit_mid)] <= rec_tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q    <= '0;
			out_rd_q    <= '0;
			out_count_q <= '0;
		end else begin
			out_wr_q    <= out_wr_q + OPTR_W'(out_push_n);
			if (out_take) begin
				out_rd_q <= out_rd_q + OPTR_W'(1);
			end
			out_count_q <= out_count_q + out_push_n - OCNT_W'(out_take);
		end
	end

	assign run_valid        = (out_count_q != '0);
	assign run_row          = out_q[out_rd_q].run_row;
	assign run_begin        = out_q[out_rd_q].run_begin;
	assign run_end          = out_q[out_rd_q].run_end;
	assign count_above      = out_q[out_rd_q].count_above;
	assign count_below      = out_q[out_rd_q].count_below;
	assign last             = out_q[out_rd_q].last;
	assign status.out_count = out_count_q;

endmodule

>>> src/binary_run_extract_with_adjacency.sv
// path: a record passes the item queue, the retire stage and the result queue to the result port
// throughput: one pixel per cycle while the result queue has room for two records; results
// leave at one per cycle unless run_stall holds them, and a pixel may cause two
// reset: dimension registers return to 640 x 480, row and column counters and run state
// clear, both queues empty; line stores are not cleared and need no clearing pass
module binary_run_extract_with_adjacency (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic                          pixel,
	output logic                          run_valid,
	input  logic                          run_stall,
	output logic [brex_pkg::FIELD_W-1:0]  run_row,
	output logic [brex_pkg::FIELD_W-1:0]  run_begin,
	output logic [brex_pkg::FIELD_W-1:0]  run_end,
	output logic [brex_pkg::FIELD_W-1:0]  count_above,
	output logic [brex_pkg::FIELD_W-1:0]  count_below,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [brex_pkg::DIM_W-1:0]    cfg_data
);

	localparam int OCNT_W    = brex_pkg::OCNT_W;
	localparam int OUT_DEPTH = brex_pkg::OUT_DEPTH;

	brex_pkg::queue_status_t q_status;
	brex_pkg::back_status_t  back_status;
	brex_pkg::item_t         front_item;
	brex_pkg::item_t         head_item;
	logic                    push;
	logic                    pop;

	brex_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.pixel_stall (pixel_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_status    (q_status),
		.push        (push),
		.item        (front_item)
	);

	brex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.pop      (pop),
		.item_out (head_item),
		.status   (q_status)
	);

	brex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (head_item),
		.q_status    (q_status),
		.pop         (pop),
		.run_valid   (run_valid),
		.run_stall   (run_stall),
		.run_row     (run_row),
		.run_begin   (run_begin),
		.run_end     (run_end),
		.count_above (count_above),
		.count_below (count_below),
		.last        (last),
		.status      (back_status)
	);

	// back end never pulls from an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty item queue");

	// an accepted pixel is held in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> !q_status.empty)
		else $error("accepted transaction lost");

	// result queue never overfills
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.out_count <= OCNT_W'(OUT_DEPTH))
		else $error("result queue overflow");

endmodule
